// ----- src/ftn4d_pkg.sv -----
// shared types and constants for the 4d network address parser
`default_nettype none

package ftn4d_pkg;

  // number width of the zone, net, node and point fields
  localparam int FIELD_BITS = 16;

  // character codes
  localparam logic [7:0] CH_ZONE_SEP = 8'h3A;
  localparam logic [7:0] CH_NET_SEP  = 8'h2F;
  localparam logic [7:0] CH_NODE_SEP = 8'h2E;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;

  // decimal radix at field width
  localparam logic [FIELD_BITS-1:0] RADIX = FIELD_BITS'(10);

  // one input request: a character or the end mark
  typedef struct packed {
    logic [7:0] character;
    logic       is_end;
  } in_t;

  // one parsed address
  typedef struct packed {
    logic [FIELD_BITS-1:0] zone;
    logic [FIELD_BITS-1:0] net;
    logic [FIELD_BITS-1:0] node;
    logic [FIELD_BITS-1:0] point;
    logic                  valid_res;
  } out_t;

  // hand-off from the parse core to the result register
  typedef struct packed {
    logic load;
    out_t data;
  } res_load_t;

endpackage

`default_nettype wire

// ----- src/ftn4d_parse_core.sv -----
// parse state and one-pass character update logic
`default_nettype none

module ftn4d_parse_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire ftn4d_pkg::in_t     item,
  output ftn4d_pkg::res_load_t    res
);

  localparam int FB = ftn4d_pkg::FIELD_BITS;

  logic [FB-1:0] acc_r, acc_nxt;
  logic [FB-1:0] zone_r, zone_nxt;
  logic [FB-1:0] net_r, net_nxt;
  logic [FB-1:0] node_r, node_nxt;
  logic          seen_zone_r, seen_zone_nxt;
  logic          seen_net_r, seen_net_nxt;
  logic          seen_node_r, seen_node_nxt;
  logic          err_r, err_nxt;
  logic [7:0]    digit_off;
  logic [FB-1:0] acc_digit;
  logic          is_digit;

  // decimal step of the accumulator, wraps at field width
  assign digit_off = item.character - ftn4d_pkg::CH_DIGIT_LO;
  assign is_digit  = (item.character >= ftn4d_pkg::CH_DIGIT_LO) &&
                     (item.character <= ftn4d_pkg::CH_DIGIT_HI);
  assign acc_digit = FB'(acc_r * ftn4d_pkg::RADIX) + {{(FB-4){1'b0}}, digit_off[3:0]};

  // next state and result
  always_comb begin
    acc_nxt       = acc_r;
    zone_nxt      = zone_r;
    net_nxt       = net_r;
    node_nxt      = node_r;
    seen_zone_nxt = seen_zone_r;
    seen_net_nxt  = seen_net_r;
    seen_node_nxt = seen_node_r;
    err_nxt       = err_r;
    res           = '0;
    if (take) begin
      if (item.is_end) begin
        res.load = 1'b1;
        if (!err_r) begin
          res.data.valid_res = 1'b1;
          res.data.zone      = zone_r;
          res.data.net       = net_r;
          res.data.node      = node_r;
          if (seen_zone_r && !seen_net_r) begin
            res.data.net = acc_r;
          end else if (seen_node_r) begin
            res.data.point = acc_r;
          end else begin
            res.data.node = acc_r;
          end
        end
        // clear for the next address
        acc_nxt       = '0;
        zone_nxt      = '0;
        net_nxt       = '0;
        node_nxt      = '0;
        seen_zone_nxt = 1'b0;
        seen_net_nxt  = 1'b0;
        seen_node_nxt = 1'b0;
        err_nxt       = 1'b0;
      end else if (!err_r) begin
        case (item.character)
          ftn4d_pkg::CH_ZONE_SEP: begin
            if (seen_zone_r || seen_net_r || seen_node_r) begin
              err_nxt = 1'b1;
            end else begin
              zone_nxt      = acc_r;
              seen_zone_nxt = 1'b1;
              acc_nxt       = '0;
            end
          end
          ftn4d_pkg::CH_NET_SEP: begin
            if (seen_net_r || seen_node_r) begin
              err_nxt = 1'b1;
            end else begin
              net_nxt      = acc_r;
              seen_net_nxt = 1'b1;
              acc_nxt      = '0;
            end
          end
          ftn4d_pkg::CH_NODE_SEP: begin
            if (seen_node_r) begin
              err_nxt = 1'b1;
            end else begin
              node_nxt      = acc_r;
              seen_node_nxt = 1'b1;
              acc_nxt       = '0;
            end
          end
          default: begin
            if (is_digit) begin
              acc_nxt = acc_digit;
            end else begin
              err_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      zone_r      <= '0;
      net_r       <= '0;
      node_r      <= '0;
      seen_zone_r <= 1'b0;
      seen_net_r  <= 1'b0;
      seen_node_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      zone_r      <= zone_nxt;
      net_r       <= net_nxt;
      node_r      <= node_nxt;
      seen_zone_r <= seen_zone_nxt;
      seen_net_r  <= seen_net_nxt;
      seen_node_r <= seen_node_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/ftn4d_out_reg.sv -----
// result register with valid/stall handshake
`default_nettype none

module ftn4d_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ftn4d_pkg::res_load_t res,
  output logic                      ready,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ftn4d_pkg::out_t           out_data
);

  logic            vld_r, vld_nxt;
  ftn4d_pkg::out_t data_r;

  // register can take a new result when empty or being drained
  assign ready = !vld_r || !out_stall;

  // valid tracking
  always_comb begin
    vld_nxt = vld_r;
    if (res.load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res.load) begin
      data_r <= res.data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ----- src/ftn_4d_address_parser.sv -----
// top level of the 4d network address parser
`default_nettype none

// Parses zone:net/node.point addresses one character per request. A request
// lands in an input register; from there the parse core updates its state
// and, on an end request, loads the result register. Throughput is one
// request per clock when the result side does not stall: the input register
// drains every cycle for character requests and for end requests whenever
// the result register is empty or being read. Numbers wrap at 16 bits; any
// syntax error yields a result with valid_res low and all numbers zero.

module ftn_4d_address_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ftn4d_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ftn4d_pkg::out_t      out_data
);

  logic                 in_vld_r, in_vld_nxt;
  ftn4d_pkg::in_t       in_data_r;
  logic                 res_ready;
  logic                 advance;
  ftn4d_pkg::res_load_t res;

  // input register drains unless an end request waits on a full result
  assign advance  = in_vld_r && (!in_data_r.is_end || res_ready);
  assign in_stall = in_vld_r && !advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // parse state update
  ftn4d_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (advance),
    .item  (in_data_r),
    .res   (res)
  );

  // result register
  ftn4d_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/ftn4d_checker.sv -----
// checker for the 4d address parser: predicts each parsed address and compares results
module ftn4d_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  ftn4d_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  ftn4d_pkg::out_t out_data,
  output int              mismatches,
  output int              pending
);
  import ftn4d_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // predicted parse state
  logic [FIELD_BITS-1:0] acc;
  logic [FIELD_BITS-1:0] zone_val;
  logic [FIELD_BITS-1:0] net_val;
  logic [FIELD_BITS-1:0] node_val;
  logic                  zone_seen;
  logic                  net_seen;
  logic                  node_seen;
  logic                  syntax_err;

  // parsed addresses still waiting to come out
  out_t addr_q[$];
  int   bad_count = 0;

  function automatic void clear_parse();
    acc = '0;
    zone_val = '0;
    net_val = '0;
    node_val = '0;
    zone_seen = 1'b0;
    net_seen = 1'b0;
    node_seen = 1'b0;
    syntax_err = 1'b0;
  endfunction

  // one character request; separators must come in rank order, once each
  function automatic void take_char(logic [7:0] c);
    if (syntax_err) return;
    case (c)
      CH_ZONE_SEP: begin
        if (zone_seen || net_seen || node_seen) begin
          syntax_err = 1'b1;
        end else begin
          zone_val = acc;
          zone_seen = 1'b1;
          acc = '0;
        end
      end
      CH_NET_SEP: begin
        if (net_seen || node_seen) begin
          syntax_err = 1'b1;
        end else begin
          net_val = acc;
          net_seen = 1'b1;
          acc = '0;
        end
      end
      CH_NODE_SEP: begin
        if (node_seen) begin
          syntax_err = 1'b1;
        end else begin
          node_val = acc;
          node_seen = 1'b1;
          acc = '0;
        end
      end
      default: begin
        if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
          acc = acc * RADIX + FIELD_BITS'(c - CH_DIGIT_LO);
        end else begin
          syntax_err = 1'b1;
        end
      end
    endcase
  endfunction

  // end request: the trailing number goes to net, point or node
  function automatic out_t close_address();
    out_t r;
    r = '0;
    if (!syntax_err) begin
      r.valid_res = 1'b1;
      r.zone = zone_val;
      r.net = net_val;
      r.node = node_val;
      if (zone_seen && !net_seen) begin
        r.net = acc;
      end else if (node_seen) begin
        r.point = acc;
      end else begin
        r.node = acc;
      end
    end
    return r;
  endfunction

  task automatic report(string what, out_t want, out_t got);
    bad_count++;
    if (bad_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected %0d:%0d/%0d.%0d ok=%0b, got %0d:%0d/%0d.%0d ok=%0b",
               $realtime, what, want.zone, want.net, want.node, want.point, want.valid_res,
               got.zone, got.net, got.node, got.point, got.valid_res);
    end
  endtask

  // watch both channels at the clock edge
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_parse();
      addr_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (addr_q.size() == 0) begin
          report("unexpected address", '0, out_data);
        end else begin
          want = addr_q.pop_front();
          if (out_data.zone !== want.zone || out_data.net !== want.net ||
              out_data.node !== want.node || out_data.point !== want.point ||
              out_data.valid_res !== want.valid_res) begin
            report("address mismatch", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.is_end) begin
          addr_q.push_back(close_address());
          clear_parse();
        end else begin
          take_char(in_data.character);
        end
      end
    end
    mismatches <= bad_count;
    pending <= addr_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// testbench top for the 4d address parser: stimulus, idling and verdict
module tb;
  import ftn4d_pkg::*;

  localparam int IDLE_PCT       = 14;
  localparam int RAND_ITEMS     = 1950;
  localparam int QUIET_FROM     = 600;
  localparam int QUIET_TO       = 900;
  localparam int DRAIN_AT       = 1200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic quiet = 1'b0;
  int   sent = 0;
  int   mismatches;
  int   pending;
  int   stuck_cycles = 0;

  ftn_4d_address_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ftn4d_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls at random outside the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one request, with random gaps ahead of it
  task automatic send_item(logic [7:0] c, logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{character: c, is_end: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // characters of one address followed by the end request
  task automatic send_addr(byte unsigned txt[$]);
    foreach (txt[i]) send_item(txt[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(string s);
    byte unsigned txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_addr(txt);
  endtask

  // well-formed address: optional zone, optional net, node, optional point
  task automatic make_address(output byte unsigned txt[$]);
    int nd;
    txt = {};
    for (int s = 0; s < 4; s++) begin
      if (s == 2 || $urandom_range(1)) begin
        if (s == 3) txt.push_back(CH_NODE_SEP);
        nd = ($urandom_range(99) < 10) ? $urandom_range(6, 7) : $urandom_range(0, 4);
        repeat (nd) txt.push_back(CH_DIGIT_LO + 8'($urandom_range(9)));
        if (s == 0) txt.push_back(CH_ZONE_SEP);
        else if (s == 1) txt.push_back(CH_NET_SEP);
      end
    end
  endtask

  initial begin
    byte unsigned txt[$];
    byte unsigned junk;
    int kind;
    logic drained;
    drained = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty, zone without net, net/node.point, wrap, bad order, bad bytes
    send_text("");
    send_text("1:23");
    send_text("9/8.7");
    send_text("70000");
    send_text("./");
    txt = {8'h00};
    send_addr(txt);
    txt = {8'hFF};
    send_addr(txt);

    // random addresses: mostly well formed, some corrupted, some noise
    while (sent < RAND_ITEMS + 25) begin
      quiet = (sent >= QUIET_FROM && sent < QUIET_TO);
      if (!drained && sent >= DRAIN_AT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      kind = $urandom_range(99);
      make_address(txt);
      if (kind >= 90) begin
        txt = {};
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
      end else if (kind >= 75) begin
        case ($urandom_range(3))
          0:       junk = CH_ZONE_SEP;
          1:       junk = CH_NET_SEP;
          2:       junk = CH_NODE_SEP;
          default: junk = 8'($urandom_range(255));
        endcase
        txt.insert($urandom_range(txt.size()), junk);
      end
      send_addr(txt);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // wait for every address, then a little longer for strays
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ftn4d_pkg.sv
src/ftn4d_parse_core.sv
src/ftn4d_out_reg.sv
src/ftn_4d_address_parser.sv
tb/ftn4d_checker.sv
tb/tb.sv
